// File: hdl/rdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rdq_pkg;

   localparam int VALUE_W       = 32;
   localparam int COMMAND_W     = 3;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 11;

   // command codes
   localparam logic [COMMAND_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [COMMAND_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [COMMAND_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [COMMAND_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [COMMAND_W-1:0] CMD_REVERSE    = 3'd4;
   localparam logic [COMMAND_W-1:0] CMD_COUNT      = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [COMMAND_W-1:0]      command;
      logic signed [VALUE_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] popped_value;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } rsp_type;

   // classified operation handed from front to back (address travels beside it)
   typedef struct packed {
      logic                      wr;
      logic                      rd;
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } op_type;

endpackage
`default_nettype wire

// File: hdl/rdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hdl/rdq_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rdq_front #(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire rdq_pkg::req_type         req_item,
   input  wire logic                     queue_full,
   output logic                          busy,
   output logic                          enq,
   output rdq_pkg::op_type               enq_op,
   output logic [$clog2(DEPTH)-1:0]      enq_addr
);
   import rdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int SW = AW + 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;

   logic          accept;
   logic          is_full, is_empty;
   logic [AW-1:0] head_dec, head_inc;
   logic [SW-1:0] tail_sum, last_sum;
   logic [AW-1:0] tail_idx, last_idx;
   logic          at_front;

   assign busy   = queue_full | reset;
   assign accept = start & ~busy;
   assign enq    = accept;

   // ring index arithmetic
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
   assign tail_sum = {1'b0, head_ff} + SW'(count_ff);
   assign last_sum = tail_sum - SW'(1);
   assign tail_idx = AW'((tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum);
   assign last_idx = AW'((last_sum >= DEPTH_S) ? last_sum - DEPTH_S : last_sum);

   // classify command against the reverse flag and update bookkeeping
   always_comb begin
      head_in            = head_ff;
      count_in           = count_ff;
      rev_in             = rev_ff;
      at_front           = 1'b0;
      enq_addr           = tail_idx;
      enq_op.wr          = 1'b0;
      enq_op.rd          = 1'b0;
      enq_op.status      = STATUS_OK;
      enq_op.value       = req_item.push_value;
      case (req_item.command)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            at_front = (req_item.command == CMD_PUSH_BACK) ? rev_ff : ~rev_ff;
            if (is_full) begin
               enq_op.status = STATUS_FULL;
            end else begin
               enq_op.wr = 1'b1;
               count_in  = count_ff + CW'(1);
               if (at_front) begin
                  head_in  = head_dec;
                  enq_addr = head_dec;
               end else begin
                  enq_addr = tail_idx;
               end
            end
         end
         CMD_POP_BACK, CMD_POP_FRONT: begin
            at_front = (req_item.command == CMD_POP_BACK) ? rev_ff : ~rev_ff;
            if (is_empty) begin
               enq_op.status = STATUS_EMPTY;
            end else begin
               enq_op.rd = 1'b1;
               count_in  = count_ff - CW'(1);
               if (at_front) begin
                  head_in  = head_inc;
                  enq_addr = head_ff;
               end else begin
                  enq_addr = last_idx;
               end
            end
         end
         CMD_REVERSE: begin
            rev_in = ~rev_ff;
         end
         default: begin
         end
      endcase
      enq_op.entry_count = ENTRY_COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/rdq_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rdq_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/rdq_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rdq_back #(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     queue_empty,
   input  wire rdq_pkg::op_type          deq_op,
   input  wire logic [$clog2(DEPTH)-1:0] deq_addr,
   output logic                          deq,
   output logic                          rsp_strobe,
   output rdq_pkg::rsp_type              rsp_item
);
   import rdq_pkg::*;

   logic                   pend_ff, pend_in;
   op_type                 op_ff;
   logic [VALUE_W-1:0]     ram_rdata;

   // drain one operation per cycle, results cannot be held off
   assign deq     = ~queue_empty;
   assign pend_in = deq;

   rdq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (deq & deq_op.wr),
      .addr  (deq_addr),
      .wdata (deq_op.value),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deq) begin
         op_ff <= deq_op;
      end
   end

   // result transaction, popped data arrives from the registered ram read
   always_comb begin
      rsp_strobe            = pend_ff;
      rsp_item.status       = op_ff.status;
      rsp_item.popped_value = op_ff.rd ? signed'(ram_rdata) : '0;
      rsp_item.entry_count  = op_ff.entry_count;
   end

endmodule
`default_nettype wire

// File: hdl/reversible_deque_core.sv
// a command accepted by the front is held in the front-to-back queue, then passes the registered
// ram read and the result registers before its result strobe goes high
// throughput: one command per cycle, set by the single ram port used once per command
// busy is high only during reset or when the front-to-back queue is full
// the receiver cannot stall, so the back side drains every cycle and busy stays low
// reset (synchronous, active high) empties the deque and clears the reverse flag
`timescale 1ns / 1ps
`default_nettype none
module reversible_deque_core #(
   parameter int DEPTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire rdq_pkg::req_type req_item,
   output logic                  busy,
   output logic                  rsp_strobe,
   output rdq_pkg::rsp_type      rsp_item
);
   import rdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int QW = $bits(op_type) + AW;

   logic          enq, deq, queue_full, queue_empty;
   op_type        enq_op, deq_op;
   logic [AW-1:0] enq_addr, deq_addr;
   logic [QW-1:0] deq_data;

   rdq_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .queue_full (queue_full),
      .busy       (busy),
      .enq        (enq),
      .enq_op     (enq_op),
      .enq_addr   (enq_addr)
   );

   rdq_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (enq),
      .push_data ({enq_op, enq_addr}),
      .pop       (deq),
      .pop_data  (deq_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign deq_op   = deq_data[QW-1:AW];
   assign deq_addr = deq_data[AW-1:0];

   rdq_back #(.DEPTH(DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .deq_op      (deq_op),
      .deq_addr    (deq_addr),
      .deq         (deq),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   // each accepted transaction yields exactly one result strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy, 2))
      else $error("result strobe does not follow accepted transaction");

   // back side always drains, so the queue never backs up
   assert property (@(posedge clock) disable iff (reset) !queue_full)
      else $error("front-to-back queue filled up");

   // a refused pop only happens on an empty deque
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == STATUS_EMPTY |-> rsp_item.entry_count == '0)
      else $error("empty status with nonzero count");

   // a refused push only happens on a full deque
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == STATUS_FULL
      |-> rsp_item.entry_count == ENTRY_COUNT_W'(DEPTH))
      else $error("full status with count below depth");

   // one classified operation never both writes and reads the ram
   assert property (@(posedge clock) disable iff (reset) enq |-> !(enq_op.wr && enq_op.rd))
      else $error("operation both writes and reads");

endmodule
`default_nettype wire
